@@ src/mie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, codes and sizes for the minimum-ID election manager.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  // Default configuration
  localparam int NumReasonsDef = 4;
  localparam int IdBitsDef     = 16;

  // Fixed field widths
  localparam int ModeW   = 3;
  localparam int ReasonW = 2;
  localparam int CandW   = 16;
  localparam int CntW    = 8;
  localparam int KindW   = 2;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [ModeW-1:0] {
    MODE_START   = 3'd0,
    MODE_REQUEST = 3'd1,
    MODE_ACK     = 3'd2,
    MODE_FINISH  = 3'd3,
    MODE_SET_NB  = 3'd4
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_CANDIDACY = 2'd0,
    KIND_ACK       = 2'd1,
    KIND_FINISH    = 2'd2,
    KIND_WON       = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [ReasonW-1:0] reason;
    logic [CandW-1:0]   candidate_id;
    logic [CntW-1:0]    neighbor_count;
  } mie_item_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ReasonW-1:0] out_reason;
    logic [CandW-1:0]   out_candidate;
    logic               last;
  } mie_result_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the event against the entry table
    logic walk;  // one step of the neighbor-drop walk
  } mie_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic walk_need;  // neighbor count drops, walk the table
    logic walk_done;  // walk index sits on the last entry
  } mie_status_t;

endpackage

`default_nettype wire

@@ src/mie_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer: capture, execute, then optionally walk the entry table.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire mie_pkg::mie_status_t status_i,
  output mie_pkg::mie_cmd_t         cmd_o,
  output logic                      busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && start_i;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.walk = (state_q == ST_WALK);
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (status_i.walk_need) begin
            state_q <= ST_WALK;
          end else begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_WALK: begin
          if (status_i.walk_done) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/mie_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_datapath
// Entry table, item register, vote logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_datapath #(
  parameter int NUM_REASONS = mie_pkg::NumReasonsDef,
  parameter int ID_BITS     = mie_pkg::IdBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mie_pkg::mie_cmd_t                   cmd_i,
  output mie_pkg::mie_status_t                     status_o,
  input  wire mie_pkg::mie_item_t                  item_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [mie_pkg::CandW-1:0]           cfg_wdata_i,
  output logic                                     result_valid_o,
  output mie_pkg::mie_result_t                     result_o
);

  localparam int IdxW  = (NUM_REASONS > 1) ? $clog2(NUM_REASONS) : 1;
  localparam int CandW = (ID_BITS < mie_pkg::CandW) ? ID_BITS : mie_pkg::CandW;
  localparam int CntW  = mie_pkg::CntW;

  mie_pkg::mie_item_t          item_q;
  logic [mie_pkg::CandW-1:0]   self_q;
  logic [CntW-1:0]             cur_nb_q;
  logic [IdxW-1:0]             walk_idx_q;
  logic [NUM_REASONS-1:0]      valid_q;
  logic [CandW-1:0]            cand_q    [NUM_REASONS];
  logic [CntW-1:0]             for_q     [NUM_REASONS];
  logic [CntW-1:0]             against_q [NUM_REASONS];
  logic [CntW-1:0]             await_q   [NUM_REASONS];
  logic                        res_valid_q;
  mie_pkg::mie_result_t        res_q;

  logic                        res_valid_d;
  mie_pkg::mie_result_t        res_d;
  logic [CntW-1:0]             cur_nb_d;

  logic [CandW-1:0]            cand_m, self_m;
  logic [CntW-1:0]             nb;
  logic                        reason_ok;
  logic [IdxW-1:0]             rsn_idx, rd_idx;
  logic                        e_valid;
  logic [CandW-1:0]            e_cand;
  logic [CntW-1:0]             e_for, e_against, e_await;

  // entry write port
  logic                        ent_we;
  logic [CandW-1:0]            nv_cand;
  logic [CntW-1:0]             nv_for, nv_against, nv_await;
  logic                        vld_we, vld_nv;

  logic [NUM_REASONS-1:0]      win_vec, later_win;

  assign cand_m    = item_q.candidate_id[CandW-1:0];
  assign self_m    = self_q[CandW-1:0];
  assign nb        = item_q.neighbor_count;
  assign reason_ok = 32'(item_q.reason) < NUM_REASONS;
  assign rsn_idx   = IdxW'(item_q.reason);
  assign rd_idx    = cmd_i.walk ? walk_idx_q : rsn_idx;

  assign e_valid   = valid_q[rd_idx];
  assign e_cand    = cand_q[rd_idx];
  assign e_for     = for_q[rd_idx];
  assign e_against = against_q[rd_idx];
  assign e_await   = await_q[rd_idx];

  // Entries that win once the awaited count becomes the new neighbor count
  always_comb begin
    for (int j = 0; j < NUM_REASONS; j++) begin
      win_vec[j]   = valid_q[j] && (for_q[j] == nb) && (against_q[j] == '0);
      later_win[j] = win_vec[j] && (IdxW'(j) > walk_idx_q);
    end
  end

  assign status_o.walk_need = (mie_pkg::mode_e'(item_q.mode) == mie_pkg::MODE_SET_NB)
                              && (cur_nb_q > nb);
  assign status_o.walk_done = (walk_idx_q == IdxW'(NUM_REASONS - 1));

  always_comb begin
    logic [CntW-1:0] inc_for, inc_against;
    logic            won;

    res_valid_d = 1'b0;
    res_d       = res_q;
    cur_nb_d    = cur_nb_q;
    ent_we      = 1'b0;
    nv_cand     = e_cand;
    nv_for      = e_for;
    nv_against  = e_against;
    nv_await    = e_await;
    vld_we      = 1'b0;
    vld_nv      = 1'b0;
    inc_for     = e_for;
    inc_against = e_against;
    won         = 1'b0;

    if (cmd_i.exec) begin
      if (mie_pkg::mode_e'(item_q.mode) == mie_pkg::MODE_SET_NB) begin
        cur_nb_d = nb;
      end else if (reason_ok) begin
        res_d.out_reason = item_q.reason;
        res_d.last       = 1'b1;
        unique case (mie_pkg::mode_e'(item_q.mode))
          mie_pkg::MODE_START: begin
            if (!e_valid) begin
              ent_we              = 1'b1;
              vld_we              = 1'b1;
              vld_nv              = 1'b1;
              nv_cand             = self_m;
              nv_for              = '0;
              nv_against          = '0;
              nv_await            = cur_nb_q;
              res_valid_d         = 1'b1;
              res_d.kind          = mie_pkg::KIND_CANDIDACY;
              res_d.out_candidate = mie_pkg::CandW'(self_m);
            end
          end
          mie_pkg::MODE_REQUEST: begin
            ent_we = 1'b1;
            if (e_valid) begin
              if (e_cand > cand_m) nv_cand = cand_m;
            end else begin
              vld_we     = 1'b1;
              vld_nv     = 1'b1;
              nv_cand    = cand_m;
              nv_for     = '0;
              nv_against = '0;
              nv_await   = cur_nb_q;
            end
            res_valid_d         = 1'b1;
            res_d.kind          = mie_pkg::KIND_ACK;
            res_d.out_candidate = mie_pkg::CandW'(nv_cand);
          end
          mie_pkg::MODE_ACK: begin
            if (e_valid) begin
              if (cand_m == self_m) begin
                if (e_for != mie_pkg::CntMax) inc_for = e_for + CntW'(1);
              end else begin
                if (e_against != mie_pkg::CntMax) inc_against = e_against + CntW'(1);
              end
              ent_we     = 1'b1;
              nv_for     = inc_for;
              nv_against = inc_against;
              won        = (inc_for == e_await) && (inc_against == '0);
              if (won) begin
                res_valid_d         = 1'b1;
                res_d.kind          = mie_pkg::KIND_WON;
                res_d.out_candidate = '0;
              end
            end
          end
          mie_pkg::MODE_FINISH: begin
            vld_we = 1'b1;
            vld_nv = 1'b0;
            if (e_valid && (e_cand == self_m)) begin
              res_valid_d         = 1'b1;
              res_d.kind          = mie_pkg::KIND_FINISH;
              res_d.out_candidate = '0;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.walk && e_valid) begin
      ent_we   = 1'b1;
      nv_await = nb;
      if (win_vec[walk_idx_q]) begin
        res_valid_d         = 1'b1;
        res_d.kind          = mie_pkg::KIND_WON;
        res_d.out_reason    = mie_pkg::ReasonW'(walk_idx_q);
        res_d.out_candidate = '0;
        res_d.last          = ~|later_win;
      end
    end
  end

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q      <= '0;
      cur_nb_q    <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      walk_idx_q  <= '0;
    end else begin
      if (cfg_we_i) self_q <= cfg_wdata_i;
      cur_nb_q    <= cur_nb_d;
      res_valid_q <= res_valid_d;
      if (vld_we) valid_q[rd_idx] <= vld_nv;
      if (cmd_i.load) begin
        walk_idx_q <= '0;
      end else if (cmd_i.walk) begin
        walk_idx_q <= walk_idx_q + IdxW'(1);
      end
    end
  end

  // payload: item, result, entry fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    res_q <= res_d;
    if (ent_we) begin
      cand_q[rd_idx]    <= nv_cand;
      for_q[rd_idx]     <= nv_for;
      against_q[rd_idx] <= nv_against;
      await_q[rd_idx]   <= nv_await;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

@@ src/min_id_election_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_id_election_manager
// Minimum-ID leader election manager: one election entry per reason.
// ----------------------------------------------------------------------------
//  channel  | signals                      | transfer
//  ---------+------------------------------+---------------------------------
//  command  | start_i, busy_o, item_i      | edge with start_i & !busy_o
//  result   | result_valid_o, result_o     | every cycle result_valid_o is high
//  config   | cfg_we_i, cfg_wdata_i        | edge with cfg_we_i (local site ID)
//
//  Start, request, ack and finish first capture the command into the item
//  register, then read-modify-write the entry; the result is registered.
//  A neighbor update that lowers the count then walks the table, one entry
//  per cycle, with at most one won result per cycle.
//  Reset clears all entry valid bits, the neighbor count and the site ID.
//  Results cannot be stalled: each one is present for one cycle only.
//  Config writes are only allowed while busy_o is low.
// ----------------------------------------------------------------------------
`default_nettype none

module min_id_election_manager #(
  parameter int NUM_REASONS = mie_pkg::NumReasonsDef,
  parameter int ID_BITS     = mie_pkg::IdBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire mie_pkg::mie_item_t         item_i,
  // config
  input  wire logic                       cfg_we_i,
  input  wire logic [mie_pkg::CandW-1:0]  cfg_wdata_i,
  // result
  output logic                            result_valid_o,
  output mie_pkg::mie_result_t            result_o
);

  mie_pkg::mie_cmd_t    cmd;
  mie_pkg::mie_status_t status;

  // sequencer: IDLE -> EXEC -> (WALK) -> IDLE
  mie_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // entry table and result register
  mie_datapath #(
    .NUM_REASONS (NUM_REASONS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTH
  // an accepted command always keeps the block busy for the execute cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after command transfer");

  // results only come out of a cycle in which the block was working
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without preceding work cycle");

  // only the neighbor walk can produce more than one result per command
  a_single_non_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.kind != mie_pkg::KIND_WON) |-> result_o.last)
    else $error("non-win result not marked last");
`endif

endmodule

`default_nettype wire

@@ tb/min_id_election_manager_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_id_election_manager_tb
// Self-checking bench for the minimum-ID election manager. Commands go in
// through the start/busy port; a scoreboard class predicts every strobed
// result and compares it field by field, in order. Runs two directed passes, a
// vote-counter saturation pass and random election traffic under three
// sender idling profiles, with the local site ID changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module min_id_election_manager_tb;

  localparam int NumReasons  = mie_pkg::NumReasonsDef;
  localparam int IdBits      = mie_pkg::IdBitsDef;
  localparam int CandW       = mie_pkg::CandW;
  localparam int CntW        = mie_pkg::CntW;
  localparam int ModeW       = mie_pkg::ModeW;
  localparam int ReasonW     = mie_pkg::ReasonW;
  localparam logic [CandW-1:0] IdMask =
      (IdBits >= CandW) ? {CandW{1'b1}} : CandW'((1 << IdBits) - 1);
  // Quiet cycles allowed after the last expected result: covers a full
  // neighbor-drop walk that may end without a result.
  localparam int DrainCycles = NumReasons + 8;
  // Cycles without any transfer before the run is declared hung.
  localparam int HangLimit   = 400;
  localparam int RandomItems = 168;
  localparam int MaxReports  = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the entry table and queues predicted results
  // --------------------------------------------------------------------------
  class election_scoreboard;
    logic                 entry_open [NumReasons];
    logic [CandW-1:0]     entry_cand [NumReasons];
    logic [CntW-1:0]      votes_yes  [NumReasons];
    logic [CntW-1:0]      votes_no   [NumReasons];
    logic [CntW-1:0]      awaited    [NumReasons];
    logic [CntW-1:0]      neighbors;
    logic [CandW-1:0]     site_id;
    mie_pkg::mie_result_t expected_results [$];
    int                   failures;

    function new();
      foreach (entry_open[i]) begin
        entry_open[i] = 1'b0;
        entry_cand[i] = '0;
        votes_yes[i]  = '0;
        votes_no[i]   = '0;
        awaited[i]    = '0;
      end
      neighbors = '0;
      site_id   = '0;
      failures  = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit has_won(int r);
      return (votes_yes[r] == awaited[r]) && (votes_no[r] == '0);
    endfunction

    function void open_entry(int r, logic [CandW-1:0] cand);
      entry_open[r] = 1'b1;
      entry_cand[r] = cand;
      votes_yes[r]  = '0;
      votes_no[r]   = '0;
      awaited[r]    = neighbors;
    endfunction

    function mie_pkg::mie_result_t make_result(mie_pkg::kind_e k, int r,
                                               logic [CandW-1:0] cand);
      mie_pkg::mie_result_t res;
      res.kind          = k;
      res.out_reason    = ReasonW'(r);
      res.out_candidate = cand;
      res.last          = 1'b0;
      return res;
    endfunction

    // Called on every accepted command transfer; queues what it must produce.
    function void note_command(mie_pkg::mie_item_t it);
      mie_pkg::mie_result_t outs [$];
      logic [CandW-1:0]     cand;
      logic [CandW-1:0]     self_id;
      int                   r;
      cand    = it.candidate_id & IdMask;
      self_id = site_id & IdMask;
      r       = int'(it.reason);
      if (it.mode == mie_pkg::MODE_SET_NB) begin
        // only a drop walks the table
        if (neighbors > it.neighbor_count) begin
          for (int i = 0; i < NumReasons; i++) begin
            if (!entry_open[i]) continue;
            awaited[i] = it.neighbor_count;
            if (has_won(i) && outs.size() < 4)
              outs.push_back(make_result(mie_pkg::KIND_WON, i, '0));
          end
        end
        neighbors = it.neighbor_count;
      end else if (it.mode <= mie_pkg::MODE_FINISH && r < NumReasons) begin
        case (it.mode)
          mie_pkg::MODE_START: begin
            if (!entry_open[r]) begin
              open_entry(r, self_id);
              outs.push_back(make_result(mie_pkg::KIND_CANDIDACY, r, self_id));
            end
          end
          mie_pkg::MODE_REQUEST: begin
            if (entry_open[r]) begin
              if (entry_cand[r] > cand) entry_cand[r] = cand;
            end else begin
              open_entry(r, cand);
            end
            outs.push_back(make_result(mie_pkg::KIND_ACK, r, entry_cand[r]));
          end
          mie_pkg::MODE_ACK: begin
            // acks to an idle reason are dropped
            if (entry_open[r]) begin
              if (cand == self_id) begin
                if (votes_yes[r] != mie_pkg::CntMax) votes_yes[r]++;
              end else begin
                if (votes_no[r] != mie_pkg::CntMax) votes_no[r]++;
              end
              if (has_won(r)) outs.push_back(make_result(mie_pkg::KIND_WON, r, '0));
            end
          end
          default: begin
            if (entry_open[r] && entry_cand[r] == self_id)
              outs.push_back(make_result(mie_pkg::KIND_FINISH, r, '0));
            entry_open[r] = 1'b0;
          end
        endcase
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_results.push_back(outs[i]);
    endfunction

    // Called on every strobed result.
    function void check_result(mie_pkg::mie_result_t got);
      mie_pkg::mie_result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("[%0t] unexpected result: kind=%0d reason=%0d cand=%h last=%b",
                   $time, got.kind, got.out_reason, got.out_candidate, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.out_reason !== want.out_reason ||
          got.out_candidate !== want.out_candidate || got.last !== want.last) begin
        failures++;
        if (failures <= MaxReports)
          $display("[%0t] result mismatch: exp kind=%0d reason=%0d cand=%h last=%b, %s",
                   $time, want.kind, want.out_reason, want.out_candidate, want.last,
                   $sformatf("got kind=%0d reason=%0d cand=%h last=%b",
                             got.kind, got.out_reason, got.out_candidate, got.last));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic                 busy_o;
  mie_pkg::mie_item_t   item_i         = '0;
  logic                 cfg_we_i       = 1'b0;
  logic [CandW-1:0]     cfg_wdata_i    = '0;
  logic                 result_valid_o;
  mie_pkg::mie_result_t result_o;

  election_scoreboard sb;
  int idle_pct   = 0;   // chance in percent that the sender idles in a cycle
  int items_sent = 0;
  int hang_count = 0;

  always #6 clk_i = ~clk_i;

  min_id_election_manager #(
    .NUM_REASONS (NumReasons),
    .ID_BITS     (IdBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Results cannot be held off: every strobed cycle is a transfer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  // Hang detector: any command or result transfer clears the count.
  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && busy_o === 1'b0) || result_valid_o === 1'b1)) begin
      hang_count <= 0;
    end else begin
      hang_count <= hang_count + 1;
    end
    if (hang_count >= HangLimit) begin
      $display("min_id_election_manager_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Each cycle the sender idles with chance idle_pct and otherwise raises start;
  // it keeps offering until the command is taken.
  task automatic issue(input logic [ModeW-1:0] mode, input logic [ReasonW-1:0] reason,
                       input logic [CandW-1:0] cand, input logic [CntW-1:0] nb);
    mie_pkg::mie_item_t it;
    bit                 offer;
    it.mode           = mode;
    it.reason         = reason;
    it.candidate_id   = cand;
    it.neighbor_count = nb;
    item_i <= it;
    do begin
      offer = ($urandom_range(0, 99) >= idle_pct);
      start_i <= offer;
      @(posedge clk_i);
    end while (!(offer && busy_o === 1'b0));
    sb.note_command(it);
    items_sent++;
  endtask

  // Stop sending, let every expected result land, then cover a silent walk.
  task automatic wait_quiet();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Only called from a quiet point.
  task automatic write_site_id(input logic [CandW-1:0] id);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.site_id = id;
  endtask

  // Candidate IDs biased toward the edges and the neighbors of the site ID.
  function automatic logic [CandW-1:0] pick_cand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sb.site_id;
      3:       return sb.site_id + 1'b1;
      4:       return sb.site_id - 1'b1;
      default: return CandW'($urandom);
    endcase
  endfunction

  // One plausible election on a random reason: neighbor setup, open, votes
  // (mostly for us), maybe a neighbor drop, then usually a finish.
  task automatic run_election();
    logic [ReasonW-1:0] r;
    int                 n;
    int                 votes;
    r     = ReasonW'($urandom_range(0, NumReasons - 1));
    n     = $urandom_range(0, 4);
    votes = $urandom_range(0, n + 2);
    if ($urandom_range(0, 1)) issue(mie_pkg::MODE_SET_NB, r, pick_cand(), CntW'(n));
    if ($urandom_range(0, 3) != 0)
      issue(mie_pkg::MODE_START, r, pick_cand(), CntW'($urandom));
    else
      issue(mie_pkg::MODE_REQUEST, r, pick_cand(), CntW'($urandom));
    repeat (votes) begin
      if ($urandom_range(0, 99) < 15)
        issue(mie_pkg::MODE_REQUEST, r, pick_cand(), CntW'($urandom));
      else
        issue(mie_pkg::MODE_ACK, r,
              ($urandom_range(0, 99) < 80) ? sb.site_id : pick_cand(),
              CntW'($urandom));
    end
    if ($urandom_range(0, 99) < 35)
      issue(mie_pkg::MODE_SET_NB, r, pick_cand(), CntW'($urandom_range(0, n)));
    if ($urandom_range(0, 99) < 80)
      issue(mie_pkg::MODE_FINISH, r, pick_cand(), CntW'($urandom));
  endtask

  // Anything the fields allow, unused modes included.
  task automatic run_noise();
    issue(ModeW'($urandom_range(0, 7)), ReasonW'($urandom), CandW'($urandom),
          $urandom_range(0, 1) ? CntW'($urandom_range(0, 5)) : CntW'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CandW-1:0] site;
    int               target;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed: site ID 0 ----
    write_site_id('0);
    issue(mie_pkg::MODE_ACK, 2'd0, '0, '0);          // ack to idle reason: dropped
    issue(mie_pkg::MODE_FINISH, 2'd1, '0, '0);       // finish on idle reason: nothing
    issue(3'd5, 2'd2, 16'h1234, 8'h12);              // unused modes
    issue(3'd7, 2'd3, '1, '1);
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'd2);     // rise: no walk
    issue(mie_pkg::MODE_START, 2'd0, '0, '0);        // candidacy, awaits 2
    issue(mie_pkg::MODE_START, 2'd0, '1, '0);        // already open: nothing
    issue(mie_pkg::MODE_ACK, 2'd0, '0, '0);
    issue(mie_pkg::MODE_ACK, 2'd0, '0, '0);          // all votes in: won
    issue(mie_pkg::MODE_REQUEST, 2'd1, '1, '0);      // opens with the offered ID
    issue(mie_pkg::MODE_REQUEST, 2'd1, 16'd7, '0);   // smaller ID wins
    issue(mie_pkg::MODE_REQUEST, 2'd1, 16'd9, '0);   // larger ID ignored
    issue(mie_pkg::MODE_START, 2'd2, '0, '0);
    issue(mie_pkg::MODE_START, 2'd3, '0, '0);
    issue(mie_pkg::MODE_ACK, 2'd3, 16'd5, '0);       // vote against
    issue(mie_pkg::MODE_ACK, 2'd2, '0, '0);
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'd1);     // drop: walk rechecks wins
    issue(mie_pkg::MODE_FINISH, 2'd0, '0, '0);       // we are the candidate: broadcast
    issue(mie_pkg::MODE_FINISH, 2'd1, '0, '0);       // someone else's: silent clear
    wait_quiet();

    // ---- directed: site ID all ones ----
    write_site_id('1);
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'hff);
    issue(mie_pkg::MODE_START, 2'd1, '0, '0);
    issue(mie_pkg::MODE_REQUEST, 2'd1, '1, '0);
    issue(mie_pkg::MODE_FINISH, 2'd3, '0, '0);
    issue(mie_pkg::MODE_START, 2'd0, '0, '0);
    issue(mie_pkg::MODE_START, 2'd3, '0, '0);
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'd0);     // drop to zero: several wins
    wait_quiet();

    // ---- vote counter saturation ----
    // Reason 0 gets 256 votes for: wins at 255 and again once pinned there,
    // then a drop to 0 must not report a win.
    write_site_id(CandW'($urandom));
    for (int i = 0; i < NumReasons; i++) issue(mie_pkg::MODE_FINISH, ReasonW'(i), '0, '0);
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'hff);
    issue(mie_pkg::MODE_START, 2'd0, '0, '0);
    repeat (256) issue(mie_pkg::MODE_ACK, 2'd0, sb.site_id, CntW'($urandom));
    issue(mie_pkg::MODE_SET_NB, 2'd0, '0, 8'd0);
    wait_quiet();

    // ---- random traffic: two phases per idling profile ----
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       site = '1;
        3:       site = '0;
        default: site = CandW'($urandom);
      endcase
      write_site_id(site);
      idle_pct = (phase < 2) ? 8 : (phase < 4) ? 57 : 0;
      target   = items_sent + RandomItems / 6;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) run_election();
        else                          run_noise();
        // occasionally hold off until everything owed has come out
        if ($urandom_range(0, 99) < 3) wait_quiet();
      end
      wait_quiet();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("min_id_election_manager_tb passed");
    end else begin
      $display("min_id_election_manager_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/mie_pkg.sv
src/mie_ctrl.sv
src/mie_datapath.sv
src/min_id_election_manager.sv
tb/min_id_election_manager_tb.sv
